FILE: rtl/core/dcmm_pkg.sv
`timescale 1ns / 1ps

package dcmm_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned SUM_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_THR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_THR = 1'd1;

  localparam logic [SUM_W-1:0]    NIGHT_THR_RESET    = 9'd303;
  localparam logic [SUM_W-1:0]    SHUTDOWN_THR_RESET = 9'd248;
  localparam logic [SAMPLE_W-1:0] BATTERY_RESET      = 8'd165;
  localparam logic [SAMPLE_W-1:0] LIGHT_RESET        = 8'd8;

  typedef struct packed {
    logic push;   // shift the beat's valid samples into the windows
    logic load;   // copy both windows into the sort arrays
    logic pass;   // run one compare-exchange pass
    logic odd;    // pass pairs (1,2),(3,4).. instead of (0,1),(2,3)..
    logic store;  // capture the result into the output register
  } dcmm_cmd_t;

endpackage

FILE: rtl/core/dcmm_ctrl.sv
`timescale 1ns / 1ps

module dcmm_ctrl #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output dcmm_pkg::dcmm_cmd_t  cmd
);

  localparam int unsigned CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] LAST_PASS = CNT_W'(WINDOW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] pass_cnt;
  logic             out_valid;
  logic             out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd       = '0;
    cmd.push  = (state == ST_IDLE) && s_tvalid;
    cmd.load  = (state == ST_LOAD);
    cmd.pass  = (state == ST_SORT);
    cmd.odd   = pass_cnt[0];
    cmd.store = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          pass_cnt <= '0;
          state    <= ST_SORT;
        end
        ST_SORT: begin
          if (pass_cnt == LAST_PASS) begin
            state <= ST_DONE;
          end else begin
            pass_cnt <= pass_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          // hold until the previous result has left
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/dcmm_datapath.sv
`timescale 1ns / 1ps

module dcmm_datapath #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dcmm_pkg::dcmm_cmd_t                 cmd,
  input  logic [dcmm_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [dcmm_pkg::IN_USER_W-1:0]      s_tuser,
  input  logic                                cfg_we,
  input  logic [dcmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcmm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [dcmm_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int unsigned MID_LO = (WINDOW - 1) / 2;
  localparam int unsigned MID_HI = WINDOW / 2;

  logic [dcmm_pkg::SAMPLE_W-1:0] bat_win [WINDOW];
  logic [dcmm_pkg::SAMPLE_W-1:0] lgt_win [WINDOW];
  logic [dcmm_pkg::SAMPLE_W-1:0] bat_srt [WINDOW];
  logic [dcmm_pkg::SAMPLE_W-1:0] lgt_srt [WINDOW];
  logic [dcmm_pkg::SAMPLE_W-1:0] bat_srt_next [WINDOW];
  logic [dcmm_pkg::SAMPLE_W-1:0] lgt_srt_next [WINDOW];

  logic [dcmm_pkg::SUM_W-1:0] night_thr;
  logic [dcmm_pkg::SUM_W-1:0] shutdown_thr;
  logic [dcmm_pkg::SUM_W-1:0] bat_sum;
  logic [dcmm_pkg::SUM_W-1:0] lgt_sum;

  logic [dcmm_pkg::SAMPLE_W-1:0] battery_raw;
  logic [dcmm_pkg::SAMPLE_W-1:0] light_raw;
  logic                          battery_ok;
  logic                          light_ok;

  logic [dcmm_pkg::SUM_W-1:0] out_bat;
  logic [dcmm_pkg::SUM_W-1:0] out_lgt;
  logic                       out_night;
  logic                       out_low;

  assign battery_raw = s_tdata[7:0];
  assign light_raw   = s_tdata[15:8];
  assign battery_ok  = s_tuser[0];
  assign light_ok    = s_tuser[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      night_thr    <= dcmm_pkg::NIGHT_THR_RESET;
      shutdown_thr <= dcmm_pkg::SHUTDOWN_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcmm_pkg::REG_NIGHT_THR:    night_thr    <= cfg_data;
        dcmm_pkg::REG_SHUTDOWN_THR: shutdown_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // windows: newest sample at entry 0, oldest dropped at the far end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        bat_win[i] <= dcmm_pkg::BATTERY_RESET;
        lgt_win[i] <= dcmm_pkg::LIGHT_RESET;
      end
    end else if (cmd.push) begin
      if (battery_ok) begin
        bat_win[0] <= battery_raw;
        for (int i = 1; i < WINDOW; i++) begin
          bat_win[i] <= bat_win[i-1];
        end
      end
      if (light_ok) begin
        lgt_win[0] <= light_raw;
        for (int i = 1; i < WINDOW; i++) begin
          lgt_win[i] <= lgt_win[i-1];
        end
      end
    end
  end

  // one odd-even transposition pass; pairs of a pass are disjoint
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      bat_srt_next[i] = bat_srt[i];
      lgt_srt_next[i] = lgt_srt[i];
    end
    for (int i = 0; i < WINDOW - 1; i++) begin
      if (((i % 2) == 1) == cmd.odd) begin
        if (bat_srt[i] > bat_srt[i+1]) begin
          bat_srt_next[i]   = bat_srt[i+1];
          bat_srt_next[i+1] = bat_srt[i];
        end
        if (lgt_srt[i] > lgt_srt[i+1]) begin
          lgt_srt_next[i]   = lgt_srt[i+1];
          lgt_srt_next[i+1] = lgt_srt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < WINDOW; i++) begin
        bat_srt[i] <= bat_win[i];
        lgt_srt[i] <= lgt_win[i];
      end
    end else if (cmd.pass) begin
      for (int i = 0; i < WINDOW; i++) begin
        bat_srt[i] <= bat_srt_next[i];
        lgt_srt[i] <= lgt_srt_next[i];
      end
    end
  end

  assign bat_sum = {1'b0, bat_srt[MID_LO]} + {1'b0, bat_srt[MID_HI]};
  assign lgt_sum = {1'b0, lgt_srt[MID_LO]} + {1'b0, lgt_srt[MID_HI]};

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      out_bat   <= bat_sum;
      out_lgt   <= lgt_sum;
      out_night <= (lgt_sum > night_thr);
      out_low   <= (bat_sum < shutdown_thr);
    end
  end

  assign m_tdata = {4'b0, out_low, out_night, out_lgt, out_bat};

endmodule

FILE: rtl/core/dual_channel_median_monitor_top.sv
`timescale 1ns / 1ps

// Dual-channel median monitor. Each input beat carries one battery and one
// light sample with their valid flags; a valid sample enters its 10-deep
// (WINDOW) window, and every beat yields one result beat with twice the median
// of each window plus the night and low-battery flags from the two threshold
// registers. One item is worked at a time, in these steps: the accepting
// cycle, which also shifts the windows, a load of the sort arrays, WINDOW
// odd-even compare-exchange passes of the sort unit, and a store of the
// result. The result waits in an output register, so a new beat is taken as
// soon as the result is stored; only a result still held there at store time
// stalls the item.
module dual_channel_median_monitor_top #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] battery_raw, [15:8] light_raw
  input  logic [dcmm_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] battery_ok, [1] light_ok
  input  logic [dcmm_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [8:0] battery_median_x2, [17:9] light_median_x2, [18] night,
  // [19] low_battery, [23:20] zero
  output logic [dcmm_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [dcmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dcmm_pkg::dcmm_cmd_t cmd;

  dcmm_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dcmm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WIN        = 10;
  localparam int unsigned LATENCY    = WIN + 3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned IDLE_PCT   = 13;
  localparam int unsigned PHASE_BEATS = 185;
  localparam int unsigned HOLD_AT    = 500;
  localparam int unsigned HOLD_LEN   = 400;

  typedef logic [dcmm_pkg::SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                       low_battery;
    logic                       night;
    logic [dcmm_pkg::SUM_W-1:0] light_med;
    logic [dcmm_pkg::SUM_W-1:0] battery_med;
  } reading_t;

  typedef struct packed {
    logic [dcmm_pkg::SAMPLE_W-1:0] battery;
    logic                          battery_ok;
    logic [dcmm_pkg::SAMPLE_W-1:0] light;
    logic                          light_ok;
    logic                          typed;   // use the typed-in reading instead of the predictor
    reading_t                      want;
  } sample_t;

  // battery, ok, light, ok, typed, {low_battery, night, light_med, battery_med}
  localparam sample_t DIRECTED [0:24] = '{
    '{8'hAA, 1'b0, 8'h55, 1'b0, 1'b1, '{1'b0, 1'b0, 9'd16,  9'd330}},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b1, '{1'b0, 1'b0, 9'd16,  9'd330}},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{8'd0,  1'b1, 8'd255, 1'b1, 1'b1, '{1'b1, 1'b1, 9'd510, 9'd0}},
    '{8'd255, 1'b1, 8'd0,  1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 8'd0,  1'b1, 1'b1, '{1'b0, 1'b0, 9'd0,   9'd510}},
    '{8'd128, 1'b1, 8'd151, 1'b1, 1'b0, '0},
    '{8'd127, 1'b1, 8'd152, 1'b1, 1'b0, '0},
    '{8'd0,  1'b0, 8'd255, 1'b0, 1'b0, '0}
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [dcmm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [dcmm_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [dcmm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_we = 1'b0;
  logic [dcmm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dcmm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [dcmm_pkg::SAMPLE_W-1:0] battery_win [WIN];
  logic [dcmm_pkg::SAMPLE_W-1:0] light_win [WIN];
  logic [dcmm_pkg::SUM_W-1:0]    night_thr = dcmm_pkg::NIGHT_THR_RESET;
  logic [dcmm_pkg::SUM_W-1:0]    shutdown_thr = dcmm_pkg::SHUTDOWN_THR_RESET;

  sample_t  sample_queue [$];
  reading_t pending_readings [$];
  sample_t  on_bus;
  logic     steady = 1'b0;
  int       errors = 0;
  int       readings_seen = 0;
  int       hold_left = 0;
  logic     held = 1'b0;
  int       cycles = 0;

  dual_channel_median_monitor_top #(
    .WINDOW(WIN)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [dcmm_pkg::SUM_W-1:0] mid_sum_x2(
    input logic [dcmm_pkg::SAMPLE_W-1:0] w [WIN]
  );
    logic [dcmm_pkg::SAMPLE_W-1:0] s [WIN];
    logic [dcmm_pkg::SAMPLE_W-1:0] t;
    int j;
    s = w;
    for (int i = 1; i < WIN; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return {1'b0, s[(WIN-1)/2]} + {1'b0, s[WIN/2]};
  endfunction

  function automatic reading_t predict_readings(input sample_t b);
    reading_t r;
    if (b.battery_ok) begin
      for (int i = WIN - 1; i > 0; i--) battery_win[i] = battery_win[i-1];
      battery_win[0] = b.battery;
    end
    if (b.light_ok) begin
      for (int i = WIN - 1; i > 0; i--) light_win[i] = light_win[i-1];
      light_win[0] = b.light;
    end
    r.battery_med = mid_sum_x2(battery_win);
    r.light_med   = mid_sum_x2(light_win);
    r.night       = r.light_med > night_thr;
    r.low_battery = r.battery_med < shutdown_thr;
    return r;
  endfunction

  // Sample source: predict on each accepted beat, then offer the next one or idle.
  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      reading_t r;
      r = predict_readings(on_bus);
      pending_readings.push_back(on_bus.typed ? on_bus.want : r);
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        on_bus = sample_queue.pop_front();
        s_tdata  <= {on_bus.light, on_bus.battery};
        s_tuser  <= {on_bus.light_ok, on_bus.battery_ok};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Reading sink: check each beat, stall at random, and hold off once for a long stretch.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      reading_t exp_r;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("reading with none expected: %h", m_tdata);
        errors++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (m_tdata[8:0] !== exp_r.battery_med) begin
          $error("battery_median_x2 expected %0d got %0d", exp_r.battery_med, m_tdata[8:0]);
          errors++;
        end
        if (m_tdata[17:9] !== exp_r.light_med) begin
          $error("light_median_x2 expected %0d got %0d", exp_r.light_med, m_tdata[17:9]);
          errors++;
        end
        if (m_tdata[18] !== exp_r.night) begin
          $error("night expected %0d got %0d", exp_r.night, m_tdata[18]);
          errors++;
        end
        if (m_tdata[19] !== exp_r.low_battery) begin
          $error("low_battery expected %0d got %0d", exp_r.low_battery, m_tdata[19]);
          errors++;
        end
        if (m_tdata[23:20] !== 4'd0) begin
          $error("pad expected 0 got %0d", m_tdata[23:20]);
          errors++;
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held && readings_seen >= HOLD_AT) begin
      held = 1'b1;
      hold_left = HOLD_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [dcmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dcmm_pkg::SUM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dcmm_pkg::REG_NIGHT_THR) night_thr = val;
    else if (idx == dcmm_pkg::REG_SHUTDOWN_THR) shutdown_thr = val;
  endtask

  // Check between edges, after all updates of the last edge have settled.
  task automatic drain();
    while (sample_queue.size() != 0 || s_tvalid || pending_readings.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Pick a burst level: half the time near the threshold crossing, a quarter at 0 or 255, else anywhere.
  function automatic int pick_level(input logic [dcmm_pkg::SUM_W-1:0] thr);
    int lvl;
    case ($urandom_range(3))
      0: lvl = $urandom_range(255);
      1: lvl = $urandom_range(1) ? 0 : 255;
      default: lvl = int'(thr >> 1) + $urandom_range(6) - 3;
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return lvl;
  endfunction

  function automatic logic [dcmm_pkg::SAMPLE_W-1:0] near(input int lvl, input int spread);
    int v;
    v = ($urandom_range(19) == 0) ? $urandom_range(255) : lvl + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[dcmm_pkg::SAMPLE_W-1:0];
  endfunction

  // Queue bursts of samples that hover around one level per channel, so the
  // medians settle and cross the thresholds instead of staying mid-range.
  task automatic queue_bursts(input int count);
    sample_t b;
    int bat_lvl, lit_lvl, spread, run;
    while (count > 0) begin
      bat_lvl = pick_level(shutdown_thr);
      lit_lvl = pick_level(night_thr);
      spread  = $urandom_range(20);
      run     = $urandom_range(30, 8);
      for (int k = 0; k < run && count > 0; k++) begin
        b = '0;
        b.battery    = near(bat_lvl, spread);
        b.light      = near(lit_lvl, spread);
        b.battery_ok = $urandom_range(99) < 85;
        b.light_ok   = $urandom_range(99) < 85;
        sample_queue.push_back(b);
        count--;
      end
    end
  endtask

  initial begin
    logic [dcmm_pkg::SUM_W-1:0] phase_thr [0:6][0:1];
    phase_thr = '{
      '{dcmm_pkg::NIGHT_THR_RESET, dcmm_pkg::SHUTDOWN_THR_RESET},
      '{9'd0,   9'd511},
      '{9'd511, 9'd0},
      '{9'd0,   9'd0},
      '{9'd511, 9'd511},
      '{9'd0,   9'd0},
      '{9'd0,   9'd0}
    };
    for (int i = 0; i < WIN; i++) begin
      battery_win[i] = dcmm_pkg::BATTERY_RESET;
      light_win[i]   = dcmm_pkg::LIGHT_RESET;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) sample_queue.push_back(DIRECTED[i]);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p >= 5) begin
        phase_thr[p][0] = sum_t'($urandom_range(511));
        phase_thr[p][1] = sum_t'($urandom_range(511));
      end
      write_reg(dcmm_pkg::REG_NIGHT_THR, phase_thr[p][0]);
      write_reg(dcmm_pkg::REG_SHUTDOWN_THR, phase_thr[p][1]);
      @(posedge clk);
      steady <= (p == 3);
      queue_bursts(PHASE_BEATS);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
